@@ design/cmbu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmbu_pkg: shared types and constants of the colour map blur update
// Map geometry, word layouts, blur weights, controller states and the
// command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package cmbu_pkg;

  localparam int MAP_SIDE = 64;
  localparam int DEPTH    = MAP_SIDE * MAP_SIDE;
  localparam int AW       = $clog2(DEPTH);
  localparam int CW       = ($clog2(MAP_SIDE) > 6) ? $clog2(MAP_SIDE) : 6;
  localparam int SW       = CW + 2;

  localparam int CRD_W    = 6;
  localparam int CH_W     = 8;
  localparam int RGB_W    = 3 * CH_W;

  localparam int WIN      = 5;
  localparam int WIN_W    = $clog2(WIN);
  localparam int TAPS     = 2 * WIN + 2;

  localparam int W_CENTER = 32;
  localparam int W_EDGE   = 10;
  localparam int W_CORNER = 7;
  localparam int SUM_W    = 15;
  localparam int DIV_MUL  = 41944;
  localparam int DIV_SH   = 22;
  localparam int PROD_W   = SUM_W + 16;

  localparam logic [CH_W-1:0] GREY_CH = CH_W'(128);

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [CRD_W-1:0] cell_x;
    logic [CRD_W-1:0] cell_y;
    logic [CH_W-1:0]  in_red;
    logic [CH_W-1:0]  in_green;
    logic [CH_W-1:0]  in_blue;
  } in_item_t;

  typedef struct packed {
    logic [CRD_W-1:0] texel_x;
    logic [CRD_W-1:0] texel_y;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic             last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_DRAIN
  } ctl_state_t;

  typedef struct packed {
    logic             clr_wr;
    logic             load_in;
    logic             wr_cell;
    logic             rd_en;
    logic [WIN_W-1:0] rd_row;
    logic [WIN_W-1:0] rd_col;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_map;
    logic adv;
    logic pipe_empty;
  } dp_sts_t;

endpackage
`default_nettype wire

@@ design/cmbu_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmbu_ram: generic simple dual-port RAM
// One write port and one read port, read data registered, held when the
// read is not enabled.
// ----------------------------------------------------------------------------
module cmbu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_dat,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_dat
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_dat_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_dat;
    end
    if (rd_en) begin
      rd_dat_r <= mem_r[rd_addr];
    end
  end

  assign rd_dat = rd_dat_r;

endmodule
`default_nettype wire

@@ design/cmbu_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmbu_ctrl: sequencing controller
// Clearing pass after reset, input capture, cell write and the raster
// sweep over the 5x5 read window, then pipeline drain.
// ----------------------------------------------------------------------------
module cmbu_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire cmbu_pkg::dp_sts_t sts,
  output cmbu_pkg::dp_cmd_t      cmd
);
  import cmbu_pkg::*;

  ctl_state_t       state_r, state_nxt;
  logic [WIN_W-1:0] win_row_r, win_row_nxt;
  logic [WIN_W-1:0] win_col_r, win_col_nxt;
  logic             win_end;

  assign win_end = (win_row_r == WIN_W'(WIN - 1)) && (win_col_r == WIN_W'(WIN - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        state_nxt = sts.in_map ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        if (sts.adv && win_end) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts.pipe_empty) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    win_row_nxt = win_row_r;
    win_col_nxt = win_col_r;
    if (state_r == ST_WRITE) begin
      win_row_nxt = '0;
      win_col_nxt = '0;
    end else if (state_r == ST_READ && sts.adv) begin
      if (win_col_r == WIN_W'(WIN - 1)) begin
        win_col_nxt = '0;
        win_row_nxt = win_row_r + WIN_W'(1);
      end else begin
        win_col_nxt = win_col_r + WIN_W'(1);
      end
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.rd_row  = win_row_r;
    cmd.rd_col  = win_col_r;
    in_stall    = 1'b1;
    unique case (state_r)
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      ST_WRITE: cmd.wr_cell = sts.in_map;
      ST_READ:  cmd.rd_en   = sts.adv;
      ST_DRAIN: cmd.rd_en   = 1'b0;
      default:  cmd.rd_en   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      win_row_r <= '0;
      win_col_r <= '0;
    end else begin
      state_r   <= state_nxt;
      win_row_r <= win_row_nxt;
      win_col_r <= win_col_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/cmbu_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmbu_dp: datapath
// Colour store, window address generation, 3-row tap line, weighted sum
// stage, divide-by-100 and the output word register.
// ----------------------------------------------------------------------------
module cmbu_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cmbu_pkg::dp_cmd_t   cmd,
  output cmbu_pkg::dp_sts_t        sts,
  input  wire cmbu_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output cmbu_pkg::out_item_t      out_data
);
  import cmbu_pkg::*;

  function automatic logic [SUM_W-1:0] chan_sum(
    input logic [CH_W-1:0] c,
    input logic [CH_W-1:0] e0, input logic [CH_W-1:0] e1,
    input logic [CH_W-1:0] e2, input logic [CH_W-1:0] e3,
    input logic [CH_W-1:0] k0, input logic [CH_W-1:0] k1,
    input logic [CH_W-1:0] k2, input logic [CH_W-1:0] k3
  );
    logic [SUM_W-1:0] es;
    logic [SUM_W-1:0] ks;
    es = SUM_W'(e0) + SUM_W'(e1) + SUM_W'(e2) + SUM_W'(e3);
    ks = SUM_W'(k0) + SUM_W'(k1) + SUM_W'(k2) + SUM_W'(k3);
    return SUM_W'(SUM_W'(c) * SUM_W'(W_CENTER) + es * SUM_W'(W_EDGE)
                  + ks * SUM_W'(W_CORNER));
  endfunction

  // floor(s / 100) by reciprocal; exact for s below 43690
  function automatic logic [CH_W-1:0] div100(input logic [SUM_W-1:0] s);
    logic [PROD_W-1:0] p;
    p = PROD_W'(s) * PROD_W'(DIV_MUL);
    return p[DIV_SH +: CH_W];
  endfunction

  logic [CRD_W-1:0] cx_r, cy_r;
  rgb_t             col_in_r;
  logic [AW-1:0]    clr_addr_r;

  logic [SW-1:0]    wx, wy;
  logic [AW-1:0]    rd_addr, cell_addr, wr_addr;
  logic             wr_en;
  rgb_t             wr_dat, rd_dat;

  logic             dvld_r;
  logic [WIN_W-1:0] drow_r, dcol_r;
  rgb_t             sh_r [TAPS];
  rgb_t             tap  [TAPS + 1];

  logic [SW-1:0]    tex_x, tex_y, x_last, y_last, cx1, cy1;
  logic             tex_ok, tex_last;

  logic             sum_vld_r;
  logic [SUM_W-1:0] sum_r_r, sum_g_r, sum_b_r;
  logic [CRD_W-1:0] tx_r, ty_r;
  logic             last_r;

  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r;
  logic             adv, out_load;

  // input word
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cx_r           <= in_data.cell_x;
      cy_r           <= in_data.cell_y;
      col_in_r.red   <= in_data.in_red;
      col_in_r.green <= in_data.in_green;
      col_in_r.blue  <= in_data.in_blue;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // store addressing
  always_comb begin
    wx = SW'(cx_r) + SW'(cmd.rd_col) - SW'(2);
    wy = SW'(cy_r) + SW'(cmd.rd_row) - SW'(2);
    if (!wx[SW-1] && !wy[SW-1] && (wx < SW'(MAP_SIDE)) && (wy < SW'(MAP_SIDE))) begin
      rd_addr = AW'(AW'(wy[CW-1:0]) * AW'(MAP_SIDE) + AW'(wx[CW-1:0]));
    end else begin
      rd_addr = '0;
    end
    cell_addr = AW'(AW'(cy_r) * AW'(MAP_SIDE) + AW'(cx_r));
  end

  assign wr_en        = cmd.clr_wr || cmd.wr_cell;
  assign wr_addr      = cmd.clr_wr ? clr_addr_r : cell_addr;
  assign wr_dat       = cmd.clr_wr ? rgb_t'({GREY_CH, GREY_CH, GREY_CH}) : col_in_r;

  cmbu_ram #(
    .WIDTH (RGB_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_dat  (wr_dat),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_dat  (rd_dat)
  );

  // pipeline advances unless a finished texel is blocked by a stalled word
  assign adv      = !(sum_vld_r && out_valid_r && out_stall);
  assign out_load = sum_vld_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r <= 1'b0;
    end else if (adv) begin
      dvld_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drow_r <= cmd.rd_row;
      dcol_r <= cmd.rd_col;
    end
  end

  // tap line over three window rows, newest word first
  always_ff @(posedge clk) begin
    if (adv && dvld_r) begin
      sh_r[0] <= rd_dat;
      for (int i = 1; i < TAPS; i++) begin
        sh_r[i] <= sh_r[i-1];
      end
    end
  end

  always_comb begin
    tap[0] = rd_dat;
    for (int i = 1; i <= TAPS; i++) begin
      tap[i] = sh_r[i-1];
    end
  end

  // texel whose bottom-right neighbour has just arrived
  always_comb begin
    tex_x  = SW'(cx_r) + SW'(dcol_r) - SW'(3);
    tex_y  = SW'(cy_r) + SW'(drow_r) - SW'(3);
    cx1    = SW'(cx_r) + SW'(1);
    cy1    = SW'(cy_r) + SW'(1);
    x_last = (cx1 > SW'(MAP_SIDE - 2)) ? SW'(MAP_SIDE - 2) : cx1;
    y_last = (cy1 > SW'(MAP_SIDE - 2)) ? SW'(MAP_SIDE - 2) : cy1;
    tex_ok = (drow_r >= WIN_W'(2)) && (dcol_r >= WIN_W'(2))
             && !tex_x[SW-1] && (tex_x != '0) && (tex_x < SW'(MAP_SIDE - 1))
             && !tex_y[SW-1] && (tex_y != '0) && (tex_y < SW'(MAP_SIDE - 1));
    tex_last = (tex_x == x_last) && (tex_y == y_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r <= 1'b0;
    end else if (adv) begin
      sum_vld_r <= dvld_r && tex_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r_r <= chan_sum(tap[6].red, tap[11].red, tap[1].red, tap[7].red, tap[5].red,
                          tap[12].red, tap[10].red, tap[2].red, tap[0].red);
      sum_g_r <= chan_sum(tap[6].green, tap[11].green, tap[1].green, tap[7].green,
                          tap[5].green, tap[12].green, tap[10].green, tap[2].green,
                          tap[0].green);
      sum_b_r <= chan_sum(tap[6].blue, tap[11].blue, tap[1].blue, tap[7].blue,
                          tap[5].blue, tap[12].blue, tap[10].blue, tap[2].blue,
                          tap[0].blue);
      tx_r    <= tex_x[CRD_W-1:0];
      ty_r    <= tex_y[CRD_W-1:0];
      last_r  <= tex_last;
    end
  end

  // output word register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.texel_x <= tx_r;
      out_data_r.texel_y <= ty_r;
      out_data_r.red     <= div100(sum_r_r);
      out_data_r.green   <= div100(sum_g_r);
      out_data_r.blue    <= div100(sum_b_r);
      out_data_r.last    <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;

  assign sts.clr_last   = (clr_addr_r == AW'(DEPTH - 1));
  assign sts.in_map     = (SW'(cx_r) < SW'(MAP_SIDE)) && (SW'(cy_r) < SW'(MAP_SIDE));
  assign sts.adv        = adv;
  assign sts.pipe_empty = !dvld_r && !sum_vld_r;

endmodule
`default_nettype wire

@@ design/color_map_blur_update.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// color_map_blur_update: colour map write with 3x3 weighted blur refresh
// Writes one RGB cell and emits the blurred interior texels around it.
// ----------------------------------------------------------------------------
//  channel  ports                         word
//  input    in_valid / in_stall / in_data   cell_x, cell_y, in_red/green/blue
//  output   out_valid / out_stall / out_data texel_x, texel_y, red/green/blue, last
//
//  A write passes through accept, store write, 25 window reads from the
//  single read port of the colour store, then a drain of the read and
//  sum stages.
//  A write outside the map gives no word.
//  After reset a clearing pass over all MAP_SIDE*MAP_SIDE cells (4096) sets the
//  map to grey; in_stall stays high meanwhile.
//  A stalled output word holds the window sweep; new input is taken while
//  the last word still waits.
// ----------------------------------------------------------------------------
module color_map_blur_update (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire cmbu_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output cmbu_pkg::out_item_t      out_data
);
  import cmbu_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  cmbu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cmbu_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
